### rtl/core/hsv_to_rgb_converter_core_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion forms for the converter pipeline.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSV2RGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsv2rgb: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HSV2RGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsv2rgb: next-cycle check failed");

`endif

### rtl/core/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Word types, fixed-point constants and small tables shared by the pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Hue fraction bits: hue counts 1/16 degree. The single-subtract
	// wrap of the hue relies on a 13-bit hue staying below two full circles.
	localparam int HUE_FRAC_BITS = 4;
	localparam int HUE_W         = 13;
	localparam int SIXTY_UNITS   = 60 << HUE_FRAC_BITS;
	localparam int CIRCLE_UNITS  = 6 * SIXTY_UNITS;

	// Widths of the intermediate values.
	localparam int CHAN_W   = 8;
	localparam int SCALE_W  = 2 * CHAN_W;
	localparam int WEIGHT_W = $clog2(SIXTY_UNITS + 1);
	localparam int PROD_W   = SCALE_W + WEIGHT_W;
	localparam int SECTOR_W = 3;

	// Division by sixty degrees: a shift by the power of two in it, then
	// division by 15 as a multiply by ceil(2^24/15) and a shift by 24.
	// Exact for dividends below 2^20, and chroma*15 stays below that.
	localparam int DIV_SHIFT   = HUE_FRAC_BITS + 2;
	localparam int QIN_W       = 20;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 21;
	localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'((1 << RECIP_SHIFT) / 15 + 1);
	localparam int QPROD_W     = QIN_W + RECIP_W;

	// Largest value on the 255*255 scale.
	localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(255 * 255);

	// Sector codes of the hue circle.
	localparam logic [SECTOR_W-1:0] SECT_RED_YEL   = 3'd0;
	localparam logic [SECTOR_W-1:0] SECT_YEL_GRN   = 3'd1;
	localparam logic [SECTOR_W-1:0] SECT_GRN_CYN   = 3'd2;
	localparam logic [SECTOR_W-1:0] SECT_CYN_BLU   = 3'd3;
	localparam logic [SECTOR_W-1:0] SECT_BLU_MAG   = 3'd4;
	localparam logic [SECTOR_W-1:0] SECT_MAG_RED   = 3'd5;

	// Input and result words.
	typedef struct packed {
		logic [HUE_W-1:0]  hue_angle;
		logic [CHAN_W-1:0] sat_level;
		logic [CHAN_W-1:0] bright_level;
	} hsv_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
	} rgb_t;

	// Front end result: sector, weight of the secondary component,
	// chroma and offset on the 255*255 scale.
	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [WEIGHT_W-1:0] weight;
		logic [SCALE_W-1:0]  chroma;
		logic [SCALE_W-1:0]  offs;
	} front_t;

	// Scaling result: secondary component as a reciprocal product.
	typedef struct packed {
		logic [SECTOR_W-1:0] sector;
		logic [QPROD_W-1:0]  qprod;
		logic [SCALE_W-1:0]  chroma;
		logic [SCALE_W-1:0]  offs;
	} scaled_t;

	// Start of each sector in hue units.
	function automatic logic [HUE_W-1:0] sector_base(input logic [SECTOR_W-1:0] sector);
		logic [HUE_W-1:0] base;
		case (sector)
			SECT_RED_YEL: base = '0;
			SECT_YEL_GRN: base = HUE_W'(SIXTY_UNITS);
			SECT_GRN_CYN: base = HUE_W'(2 * SIXTY_UNITS);
			SECT_CYN_BLU: base = HUE_W'(3 * SIXTY_UNITS);
			SECT_BLU_MAG: base = HUE_W'(4 * SIXTY_UNITS);
			SECT_MAG_RED: base = HUE_W'(5 * SIXTY_UNITS);
			default:      base = '0;
		endcase
		return base;
	endfunction

	// Division by 255 for values up to 255*255.
	function automatic logic [CHAN_W-1:0] div255(input logic [SCALE_W-1:0] x);
		logic [SCALE_W:0] t;
		t = {1'b0, x} + (SCALE_W+1)'(1) + (SCALE_W+1)'(x >> CHAN_W);
		return t[SCALE_W-1:CHAN_W];
	endfunction

endpackage

### rtl/core/hsv2rgb_front.sv
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Stage 1 wraps the hue and forms chroma; stage 2 finds the sector, the
// weight of the secondary component and the offset.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv2rgb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hsv_valid,
	output logic                hsv_ready,
	input  hsv2rgb_pkg::hsv_t   hsv,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::front_t out
);

	logic                                valid_s1;
	logic [hsv2rgb_pkg::HUE_W-1:0]       hue_s1;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     chroma_s1;
	logic [hsv2rgb_pkg::CHAN_W-1:0]      bright_s1;
	logic                                valid_s2;
	hsv2rgb_pkg::front_t                 front_s2;
	logic                                adv_s1;
	logic                                adv_s2;
	logic [hsv2rgb_pkg::HUE_W-1:0]       hue_wrap;
	logic [hsv2rgb_pkg::SECTOR_W-1:0]    sector_c;
	logic [hsv2rgb_pkg::HUE_W-1:0]       rem_c;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     full_c;
	hsv2rgb_pkg::front_t                 front_c;

	// A stage moves when it is empty or the next one moves.
	assign adv_s2    = !valid_s2 || out_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign hsv_ready = adv_s1;

	// Wrap the hue into one full circle.
	always_comb begin
		if (hsv.hue_angle >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::CIRCLE_UNITS)) begin
			hue_wrap = hsv.hue_angle - hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::CIRCLE_UNITS);
		end else begin
			hue_wrap = hsv.hue_angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= hsv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && hsv_valid) begin
			hue_s1    <= hue_wrap;
			chroma_s1 <= hsv.sat_level * hsv.bright_level;
			bright_s1 <= hsv.bright_level;
		end
	end

	// Sector from five boundary compares, then the position inside it.
	// Even sectors rise from zero, odd sectors fall from full chroma.
	always_comb begin
		sector_c = '0;
		for (int k = 1; k < 6; k++) begin
			if (hue_s1 >= hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::SIXTY_UNITS)) begin
				sector_c = sector_c + hsv2rgb_pkg::SECTOR_W'(1);
			end
		end
		rem_c  = hue_s1 - hsv2rgb_pkg::sector_base(sector_c);
		full_c = {bright_s1, {hsv2rgb_pkg::CHAN_W{1'b0}}}
			- hsv2rgb_pkg::SCALE_W'(bright_s1);
		front_c.sector = sector_c;
		if (sector_c[0]) begin
			front_c.weight = hsv2rgb_pkg::WEIGHT_W'(hsv2rgb_pkg::SIXTY_UNITS)
				- rem_c[hsv2rgb_pkg::WEIGHT_W-1:0];
		end else begin
			front_c.weight = rem_c[hsv2rgb_pkg::WEIGHT_W-1:0];
		end
		front_c.chroma = chroma_s1;
		front_c.offs   = full_c - chroma_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			front_s2 <= front_c;
		end
	end

	assign out_valid = valid_s2;
	assign out       = front_s2;

	// Checks on the front end.
	`HSV2RGB_ASSERT_NOW(a_weight_bound, clk, arst_n, valid_s2,
		front_s2.weight <= hsv2rgb_pkg::WEIGHT_W'(hsv2rgb_pkg::SIXTY_UNITS))
	`HSV2RGB_ASSERT_NOW(a_offs_bound, clk, arst_n, valid_s2,
		({1'b0, front_s2.offs} + {1'b0, front_s2.chroma}) <= {1'b0, hsv2rgb_pkg::SCALE_MAX})
	`HSV2RGB_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid_s2 && !out_ready,
		valid_s2 && $stable(front_s2))

endmodule

### rtl/core/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// HSV to RGB secondary scaling
// Stage 3 multiplies chroma by the weight; stage 4 multiplies the shifted
// product by the reciprocal of 15 to divide by sixty degrees.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hsv2rgb_pkg::front_t  in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hsv2rgb_pkg::scaled_t out
);

	logic                                valid_s3;
	logic [hsv2rgb_pkg::SECTOR_W-1:0]    sector_s3;
	logic [hsv2rgb_pkg::PROD_W-1:0]      prod_s3;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     chroma_s3;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     offs_s3;
	logic                                valid_s4;
	hsv2rgb_pkg::scaled_t                scaled_s4;
	logic                                adv_s3;
	logic                                adv_s4;
	logic [hsv2rgb_pkg::PROD_W-1:0]      shifted;
	logic [hsv2rgb_pkg::QIN_W-1:0]       qin;

	assign adv_s4   = !valid_s4 || out_ready;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign in_ready = adv_s3;

	// Chroma times weight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && in_valid) begin
			sector_s3 <= in.sector;
			prod_s3   <= in.chroma * in.weight;
			chroma_s3 <= in.chroma;
			offs_s3   <= in.offs;
		end
	end

	// Drop the power of two of the divisor, then scale by 1/15.
	assign shifted = prod_s3 >> hsv2rgb_pkg::DIV_SHIFT;
	assign qin     = shifted[hsv2rgb_pkg::QIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			scaled_s4.sector <= sector_s3;
			scaled_s4.qprod  <= qin * hsv2rgb_pkg::RECIP_15;
			scaled_s4.chroma <= chroma_s3;
			scaled_s4.offs   <= offs_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out       = scaled_s4;

endmodule

### rtl/core/hsv2rgb_mix.sv
// ----------------------------------------------------------------------------
// HSV to RGB channel mixing
// Stage 5 places chroma and the secondary component by sector and adds the
// offset; stage 6 divides each channel by 255 into the output register.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv2rgb_mix (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hsv2rgb_pkg::scaled_t in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hsv2rgb_pkg::rgb_t    out
);

	logic                                valid_s5;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     red_s5;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     green_s5;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     blue_s5;
	logic                                valid_s6;
	hsv2rgb_pkg::rgb_t                   rgb_s6;
	logic                                adv_s5;
	logic                                adv_s6;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     second;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     red_c;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     green_c;
	logic [hsv2rgb_pkg::SCALE_W-1:0]     blue_c;

	assign adv_s6   = !valid_s6 || out_ready;
	assign adv_s5   = !valid_s5 || adv_s6;
	assign in_ready = adv_s5;

	// Secondary component is the top of the reciprocal product.
	assign second = in.qprod[hsv2rgb_pkg::RECIP_SHIFT +: hsv2rgb_pkg::SCALE_W];

	// Place the components by sector.
	always_comb begin
		case (in.sector)
			hsv2rgb_pkg::SECT_RED_YEL: begin
				red_c = in.chroma; green_c = second;    blue_c = '0;
			end
			hsv2rgb_pkg::SECT_YEL_GRN: begin
				red_c = second;    green_c = in.chroma; blue_c = '0;
			end
			hsv2rgb_pkg::SECT_GRN_CYN: begin
				red_c = '0;        green_c = in.chroma; blue_c = second;
			end
			hsv2rgb_pkg::SECT_CYN_BLU: begin
				red_c = '0;        green_c = second;    blue_c = in.chroma;
			end
			hsv2rgb_pkg::SECT_BLU_MAG: begin
				red_c = second;    green_c = '0;        blue_c = in.chroma;
			end
			default: begin
				red_c = in.chroma; green_c = '0;        blue_c = second;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv_s5) begin
			valid_s5 <= in_valid;
		end
	end

	// Sums stay within 255*255 since chroma plus offset is 255*v.
	always_ff @(posedge clk) begin
		if (adv_s5 && in_valid) begin
			red_s5   <= red_c + in.offs;
			green_s5 <= green_c + in.offs;
			blue_s5  <= blue_c + in.offs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv_s6) begin
			valid_s6 <= valid_s5;
		end
	end

	// Scale each channel back to eight bits.
	always_ff @(posedge clk) begin
		if (adv_s6 && valid_s5) begin
			rgb_s6.red_out   <= hsv2rgb_pkg::div255(red_s5);
			rgb_s6.green_out <= hsv2rgb_pkg::div255(green_s5);
			rgb_s6.blue_out  <= hsv2rgb_pkg::div255(blue_s5);
		end
	end

	assign out_valid = valid_s6;
	assign out       = rgb_s6;

	// Checks on the mixing stages.
	`HSV2RGB_ASSERT_NOW(a_sum_bound, clk, arst_n, valid_s5,
		(red_s5 <= hsv2rgb_pkg::SCALE_MAX) && (green_s5 <= hsv2rgb_pkg::SCALE_MAX) && (blue_s5 <= hsv2rgb_pkg::SCALE_MAX))
	`HSV2RGB_ASSERT_NEXT(a_sum_hold, clk, arst_n, valid_s5 && !adv_s6,
		valid_s5 && $stable(red_s5) && $stable(green_s5) && $stable(blue_s5))

endmodule

### rtl/core/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Six-stage pipeline converting one HSV word to one 8-bit RGB word.
// ----------------------------------------------------------------------------
// The converter takes one HSV word per clock and returns one RGB word per
// clock when the output side is ready. The six pipeline registers are, in
// order, hue wrap and chroma, sector and weight, the chroma-by-weight
// multiplier, the reciprocal multiplier that divides by sixty degrees,
// channel placement, and the divide by 255 into the output register. A
// stall on the output holds every full stage while empty stages keep
// filling, so hsv_ready drops only when all six are full.
// Hue is in 1/16 degree; values at or above 360 degrees wrap around.
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv_to_rgb_converter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_ready,
	input  hsv2rgb_pkg::hsv_t hsv,
	output logic              rgb_valid,
	input  logic              rgb_ready,
	output hsv2rgb_pkg::rgb_t rgb
);

	logic                 front_valid;
	logic                 front_ready;
	hsv2rgb_pkg::front_t  front;
	logic                 scaled_valid;
	logic                 scaled_ready;
	hsv2rgb_pkg::scaled_t scaled;

	// Hue wrap, chroma, sector and offset.
	hsv2rgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out       (front)
	);

	// Secondary component scaling.
	hsv2rgb_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in        (front),
		.out_valid (scaled_valid),
		.out_ready (scaled_ready),
		.out       (scaled)
	);

	// Channel placement and output scaling.
	hsv2rgb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scaled_valid),
		.in_ready  (scaled_ready),
		.in        (scaled),
		.out_valid (rgb_valid),
		.out_ready (rgb_ready),
		.out       (rgb)
	);

	// The input side can only be blocked by a stalled, full output.
	`HSV2RGB_ASSERT_NOW(a_block_cause, clk, arst_n, !hsv_ready,
		rgb_valid && !rgb_ready && front_valid && scaled_valid)
	`HSV2RGB_ASSERT_NOW(a_inner_block, clk, arst_n, !front_ready,
		scaled_valid && rgb_valid && !rgb_ready)
	`HSV2RGB_ASSERT_NOW(a_drain_frees, clk, arst_n, rgb_ready,
		hsv_ready)

endmodule
